@@ sv/cdsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cdsc_pkg;

    localparam int unsigned DUTY_W    = 8;
    localparam int unsigned VOLT_W    = 13;
    localparam int unsigned TEMP_W    = 16;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_DUTY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EVAL_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MONITOR       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_STEPS  = 3'd7;

    // result status codes
    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_CHARGING   = 3'd1;
    localparam logic [2:0] ST_OVER_TEMP  = 3'd2;
    localparam logic [2:0] ST_NO_HISTORY = 3'd3;
    localparam logic [2:0] ST_IGNORED    = 3'd4;

    // sample request codes
    localparam logic [1:0] REQ_NONE     = 2'd0;
    localparam logic [1:0] REQ_UNLOADED = 2'd1;
    localparam logic [1:0] REQ_LOADED   = 2'd2;
    localparam logic [1:0] REQ_TEMP     = 2'd3;

    typedef struct packed {
        logic [7:0]  min_duty;
        logic [7:0]  max_duty;
        logic [7:0]  high_duty;
        logic [15:0] eval_interval_ms;
        logic [11:0] settle_ms;
        logic [15:0] monitor_period_ms;
        logic [14:0] temp_limit_mc;
        logic [3:0]  search_steps;
    } t_cfg;

    // packed low to high: duty_cycle, sample_request, status
    typedef struct packed {
        logic [2:0]        status;
        logic [1:0]        sample_request;
        logic [DUTY_W-1:0] duty_cycle;
    } t_result;

endpackage

`default_nettype wire

@@ sv/cdsc_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cdsc_cfg_regs (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_wr_en,
    input  wire  [cdsc_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire  [cdsc_pkg::CFG_W-1:0]     i_cfg_wdata,
    output cdsc_pkg::t_cfg                 o_cfg
);

    cdsc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_duty          <= 8'd50;
            r_cfg.max_duty          <= 8'd255;
            r_cfg.high_duty         <= 8'd227;
            r_cfg.eval_interval_ms  <= 16'd5000;
            r_cfg.settle_ms         <= 12'd200;
            r_cfg.monitor_period_ms <= 16'd1000;
            r_cfg.temp_limit_mc     <= 15'd800;
            r_cfg.search_steps      <= 4'd10;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                cdsc_pkg::REG_MIN_DUTY:      r_cfg.min_duty          <= i_cfg_wdata[7:0];
                cdsc_pkg::REG_MAX_DUTY:      r_cfg.max_duty          <= i_cfg_wdata[7:0];
                cdsc_pkg::REG_HIGH_DUTY:     r_cfg.high_duty         <= i_cfg_wdata[7:0];
                cdsc_pkg::REG_EVAL_INTERVAL: r_cfg.eval_interval_ms  <= i_cfg_wdata[15:0];
                cdsc_pkg::REG_SETTLE:        r_cfg.settle_ms         <= i_cfg_wdata[11:0];
                cdsc_pkg::REG_MONITOR:       r_cfg.monitor_period_ms <= i_cfg_wdata[15:0];
                cdsc_pkg::REG_TEMP_LIMIT:    r_cfg.temp_limit_mc     <= i_cfg_wdata[14:0];
                cdsc_pkg::REG_SEARCH_STEPS:  r_cfg.search_steps      <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ sv/cdsc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cdsc_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_accept,
    input  wire         [1:0]                   i_command,
    input  wire                                 i_history_ok,
    input  wire         [cdsc_pkg::VOLT_W-1:0]  i_voltage_mv,
    input  wire  signed [cdsc_pkg::TEMP_W-1:0]  i_temp_diff_mc,
    input  wire  cdsc_pkg::t_cfg                i_cfg,
    output cdsc_pkg::t_result                   o_result
);

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    typedef enum logic [9:0] {
        PH_IDLE             = 10'b00_0000_0001,
        PH_REF_WAIT         = 10'b00_0000_0010,
        PH_REF_SAMPLE       = 10'b00_0000_0100,
        PH_EVAL_UNLOADED    = 10'b00_0000_1000,
        PH_EVAL_HIGH_WAIT   = 10'b00_0001_0000,
        PH_EVAL_HIGH_SAMPLE = 10'b00_0010_0000,
        PH_PROBE_WAIT       = 10'b00_0100_0000,
        PH_PROBE_SAMPLE     = 10'b00_1000_0000,
        PH_MON_SAMPLE       = 10'b01_0000_0000,
        PH_MON_WAIT         = 10'b10_0000_0000
    } t_phase;

    // midpoint, halving toward zero
    function automatic logic signed [9:0] mid_of(input logic signed [9:0] lo,
                                                 input logic signed [9:0] hi);
        logic signed [10:0] span;
        logic signed [10:0] half;
        logic signed [10:0] sum;
        begin
            span = {hi[9], hi} - {lo[9], lo};
            half = (span + {10'd0, span[10]}) >>> 1;
            sum  = {lo[9], lo} + half;
            mid_of = sum[9:0];
        end
    endfunction

    function automatic logic [7:0] sat_duty(input logic signed [9:0] v);
        begin
            if (v[9])
                sat_duty = 8'd0;
            else if (v[8])
                sat_duty = 8'd255;
            else
                sat_duty = v[7:0];
        end
    endfunction

    t_phase             r_phase,       n_phase;
    logic [12:0]        r_target,      n_target;
    logic [12:0]        r_unloaded,    n_unloaded;
    logic signed [9:0]  r_low,         n_low;
    logic signed [9:0]  r_high,        n_high;
    logic [7:0]         r_best_duty,   n_best_duty;
    logic [12:0]        r_best_err,    n_best_err;
    logic [3:0]         r_probe_cnt,   n_probe_cnt;
    logic [15:0]        r_wait_cnt,    n_wait_cnt;
    logic [15:0]        r_since_eval,  n_since_eval;
    logic [7:0]         r_drive,       n_drive;

    logic [15:0]        settle_len;
    logic [15:0]        ref_len;
    logic [13:0]        mean_sum;
    logic signed [9:0]  mid_cur;
    logic signed [9:0]  mid_next;
    logic signed [13:0] diff;
    logic [12:0]        err;
    logic               over_temp;
    logic [2:0]         status;
    logic               status_set;
    logic [1:0]         req;

    assign settle_len = {4'd0, i_cfg.settle_ms};
    assign ref_len    = (settle_len << 2) + settle_len;
    assign mean_sum   = {1'b0, r_unloaded} + {1'b0, i_voltage_mv};
    assign mid_cur    = mid_of(r_low, r_high);
    assign mid_next   = mid_of(n_low, n_high);
    assign diff       = $signed({1'b0, i_voltage_mv}) - $signed({1'b0, r_target});
    assign err        = diff[13] ? 13'(-diff) : diff[12:0];
    assign over_temp  = $signed({i_temp_diff_mc[15], i_temp_diff_mc})
                        > $signed({2'b00, i_cfg.temp_limit_mc});

    always_comb begin
        n_phase      = r_phase;
        n_target     = r_target;
        n_unloaded   = r_unloaded;
        n_low        = r_low;
        n_high       = r_high;
        n_best_duty  = r_best_duty;
        n_best_err   = r_best_err;
        n_probe_cnt  = r_probe_cnt;
        n_wait_cnt   = r_wait_cnt;
        n_since_eval = r_since_eval;
        n_drive      = r_drive;
        status       = cdsc_pkg::ST_IDLE;
        status_set   = 1'b0;

        unique case (i_command)
            CMD_START: begin
                status_set = 1'b1;
                if (r_phase != PH_IDLE) begin
                    status = cdsc_pkg::ST_IGNORED;
                end else if (!i_history_ok) begin
                    n_drive = 8'd0;
                    status  = cdsc_pkg::ST_NO_HISTORY;
                end else begin
                    n_unloaded = i_voltage_mv;
                    n_drive    = i_cfg.high_duty;
                    n_phase    = PH_REF_WAIT;
                    n_wait_cnt = ref_len;
                    status     = cdsc_pkg::ST_CHARGING;
                end
            end
            CMD_TICK: begin
                if (r_since_eval != 16'hFFFF)
                    n_since_eval = r_since_eval + 16'd1;
                if (r_phase == PH_REF_WAIT || r_phase == PH_EVAL_HIGH_WAIT ||
                    r_phase == PH_PROBE_WAIT || r_phase == PH_MON_WAIT) begin
                    if (r_wait_cnt <= 16'd1) begin
                        n_wait_cnt = 16'd0;
                        priority if (r_phase == PH_REF_WAIT)
                            n_phase = PH_REF_SAMPLE;
                        else if (r_phase == PH_EVAL_HIGH_WAIT)
                            n_phase = PH_EVAL_HIGH_SAMPLE;
                        else if (r_phase == PH_PROBE_WAIT)
                            n_phase = PH_PROBE_SAMPLE;
                        else if (n_since_eval >= i_cfg.eval_interval_ms)
                            n_phase = PH_EVAL_UNLOADED;
                        else
                            n_phase = PH_MON_SAMPLE;
                    end else begin
                        n_wait_cnt = r_wait_cnt - 16'd1;
                    end
                end
            end
            CMD_SAMPLE: begin
                unique case (r_phase)
                    PH_REF_SAMPLE: begin
                        n_target = mean_sum[13:1];
                        n_phase  = PH_EVAL_UNLOADED;
                    end
                    PH_EVAL_UNLOADED: begin
                        n_unloaded = i_voltage_mv;
                        n_drive    = i_cfg.high_duty;
                        n_phase    = PH_EVAL_HIGH_WAIT;
                        n_wait_cnt = ref_len;
                    end
                    PH_EVAL_HIGH_SAMPLE: begin
                        n_target    = mean_sum[13:1];
                        n_low       = $signed({2'b00, i_cfg.min_duty});
                        n_high      = $signed({2'b00, i_cfg.max_duty});
                        n_best_err  = 13'h1FFF;
                        n_best_duty = 8'd0;
                        n_probe_cnt = 4'd0;
                        n_drive     = sat_duty(mid_next);
                        n_phase     = PH_PROBE_WAIT;
                        n_wait_cnt  = settle_len;
                    end
                    PH_PROBE_SAMPLE: begin
                        if (r_probe_cnt == 4'd0 || err < r_best_err) begin
                            n_best_err  = err;
                            n_best_duty = sat_duty(mid_cur);
                        end
                        if (!diff[13] && diff != 14'sd0)
                            n_low = mid_cur + 10'sd1;
                        else
                            n_high = mid_cur - 10'sd1;
                        n_probe_cnt = r_probe_cnt + 4'd1;
                        if (n_probe_cnt >= i_cfg.search_steps || n_probe_cnt == 4'd0) begin
                            n_drive      = n_best_duty;
                            n_since_eval = 16'd0;
                            n_phase      = PH_MON_SAMPLE;
                        end else begin
                            n_drive    = sat_duty(mid_next);
                            n_phase    = PH_PROBE_WAIT;
                            n_wait_cnt = settle_len;
                        end
                    end
                    PH_MON_SAMPLE: begin
                        if (over_temp) begin
                            n_drive    = 8'd0;
                            n_phase    = PH_IDLE;
                            status     = cdsc_pkg::ST_OVER_TEMP;
                            status_set = 1'b1;
                        end else begin
                            n_phase    = PH_MON_WAIT;
                            n_wait_cnt = i_cfg.monitor_period_ms;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_NONE: ;
            default: ;
        endcase

        if (!status_set)
            status = (n_phase != PH_IDLE) ? cdsc_pkg::ST_CHARGING : cdsc_pkg::ST_IDLE;

        unique case (n_phase)
            PH_EVAL_UNLOADED:    req = cdsc_pkg::REQ_UNLOADED;
            PH_REF_SAMPLE,
            PH_EVAL_HIGH_SAMPLE,
            PH_PROBE_SAMPLE:     req = cdsc_pkg::REQ_LOADED;
            PH_MON_SAMPLE:       req = cdsc_pkg::REQ_TEMP;
            default:             req = cdsc_pkg::REQ_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_target     <= '0;
            r_unloaded   <= '0;
            r_low        <= '0;
            r_high       <= '0;
            r_best_duty  <= '0;
            r_best_err   <= 13'h1FFF;
            r_probe_cnt  <= '0;
            r_wait_cnt   <= '0;
            r_since_eval <= '0;
            r_drive      <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_target     <= n_target;
            r_unloaded   <= n_unloaded;
            r_low        <= n_low;
            r_high       <= n_high;
            r_best_duty  <= n_best_duty;
            r_best_err   <= n_best_err;
            r_probe_cnt  <= n_probe_cnt;
            r_wait_cnt   <= n_wait_cnt;
            r_since_eval <= n_since_eval;
            r_drive      <= n_drive;
        end
    end

    assign o_result.duty_cycle     = n_drive;
    assign o_result.sample_request = req;
    assign o_result.status         = status;

endmodule

`default_nettype wire

@@ sv/charge_duty_search_controller_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Charge duty search controller.
// Slave stream carries commands (tuser: start, sample, 1 ms tick) with the
// history flag, voltage and temperature in tdata. Every transaction gives
// exactly one result transaction on the master stream: driven duty, the
// sample currently awaited and a status code.
// Configuration: write enable, 3-bit register index, 16-bit data; writes
// take effect at the clock edge and the user must make them only while the
// stream is idle; the block does not enforce this. Throughput: one
// transaction per cycle while results are taken, set by the single state
// update between the controller state registers and the output register.
// If the receiver stalls, the output register holds its result and tready
// drops only while that register is full and not being taken.
// Reset (synchronous, active low) returns registers to defaults, the
// sequencer to idle with zero duty, and empties the output register.

module charge_duty_search_controller_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,   // history_ok, voltage_mv, temp_diff_mc
    input  wire  [1:0]  i_s_axis_tuser,   // command
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // duty_cycle, sample_request, status
    input  wire         i_cfg_wr_en,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [15:0] i_cfg_wdata
);

    cdsc_pkg::t_cfg    cfg;
    cdsc_pkg::t_result result;
    cdsc_pkg::t_result r_out;
    logic              r_out_valid;
    logic              accept;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    cdsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    cdsc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_command      (i_s_axis_tuser),
        .i_history_ok   (i_s_axis_tdata[0]),
        .i_voltage_mv   (i_s_axis_tdata[13:1]),
        .i_temp_diff_mc ($signed(i_s_axis_tdata[29:14])),
        .i_cfg          (cfg),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out};

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !accept)
        else $error("input taken while result stalled");

    a_over_temp_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_out.status == cdsc_pkg::ST_OVER_TEMP
        |-> r_out.duty_cycle == 8'd0 && r_out.sample_request == cdsc_pkg::REQ_NONE)
        else $error("over-temperature stop still driving");

    a_no_history_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_out.status == cdsc_pkg::ST_NO_HISTORY
        |-> r_out.duty_cycle == 8'd0 && r_out.sample_request == cdsc_pkg::REQ_NONE)
        else $error("no-history start left duty or request active");

endmodule

`default_nettype wire
